FILE: rtl/kbb_pkg.sv
// Shared constants, datapath opcodes and controller/datapath interface types.
package kbb_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int IDX_W     = 5;   // entry index into the item store
    localparam int CNT_W     = 6;   // item count / search level, holds MAX_ITEMS
    localparam int WGT_W     = 16;
    localparam int VAL_W     = 16;
    localparam int CAP_W     = 24;
    localparam int RP_W      = 22;  // running / best profit
    localparam int BND_W     = 42;  // bound accumulator
    localparam int PRD_W     = 40;  // room * value
    localparam int REM_W     = 17;  // divider partial remainder
    localparam int NODE_W    = 32;
    localparam int MASK_W    = 32;
    localparam int PROF_W    = 21;

    typedef logic [3:0] t_op;

    localparam t_op OP_NONE   = 4'd0;
    localparam t_op OP_LATCH  = 4'd1;
    localparam t_op OP_SCAN   = 4'd2;
    localparam t_op OP_INSERT = 4'd3;
    localparam t_op OP_SINIT  = 4'd4;
    localparam t_op OP_NODE   = 4'd5;
    localparam t_op OP_BINIT  = 4'd6;
    localparam t_op OP_BSTEP  = 4'd7;
    localparam t_op OP_MUL    = 4'd8;
    localparam t_op OP_DIV    = 4'd9;
    localparam t_op OP_QADD   = 4'd10;
    localparam t_op OP_EXCL   = 4'd11;
    localparam t_op OP_POP    = 4'd12;
    localparam t_op OP_UNDO   = 4'd13;
    localparam t_op OP_FINISH = 4'd14;

    typedef logic [1:0] t_phase;

    localparam t_phase PH_ENTER = 2'd0;
    localparam t_phase PH_EXCL  = 2'd1;
    localparam t_phase PH_DONE  = 2'd2;

    typedef struct packed {
        t_op  op;
        logic rd_bidx;   // store read port follows the scan/bound index, else the level
    } t_cmd;

    typedef struct packed {
        logic   full;
        logic   last;
        logic   scan_stop;
        logic   lvl_zero;
        logic   bnd_end;
        logic   bnd_fits;
        logic   div_done;
        t_phase phase;
    } t_sts;

endpackage

FILE: rtl/knapsack_branch_and_bound_unit.sv
// Top level of the 0/1 knapsack branch-and-bound solver.
//
//  channel   | handshake              | word
//  ----------+------------------------+-------------------------------------------
//  item in   | start & !busy          | i_item_weight, i_item_value, i_last_item
//  config    | i_cfg_wr_en            | i_cfg_wr_data (sack capacity)
//  result    | o_result_valid (1 clk) | o_chosen_mask, o_total_profit,
//            |                        | o_total_weight, o_nodes_visited
//
// Load: an item is latched on accept, then scanned against the store with one ratio
// compare per scan step up to its sorted position p, then a stop step and a shift
// insert; when the store is full the item is not inserted.
// Solve: after the last item, a data-dependent search; a bound that needs the
// fractional term also runs a multiply and a bit-serial divider.
// Reset is synchronous, active low; no clearing pass. The result strobe lasts one
// cycle and cannot be stalled; busy stays high until the result is issued.
module knapsack_branch_and_bound_unit import kbb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [WGT_W-1:0]    i_item_weight,
    input  logic [VAL_W-1:0]    i_item_value,
    input  logic                i_last_item,
    input  logic                i_cfg_wr_en,
    input  logic [CAP_W-1:0]    i_cfg_wr_data,
    output logic                o_result_valid,
    output logic [MASK_W-1:0]   o_chosen_mask,
    output logic [PROF_W-1:0]   o_total_profit,
    output logic [CAP_W-1:0]    o_total_weight,
    output logic [NODE_W-1:0]   o_nodes_visited
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: load scan, insert, node dispatch, bound walk, divide
    kbb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // store, search state, divider and result registers
    kbb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_item_weight   (i_item_weight),
        .i_item_value    (i_item_value),
        .i_last_item     (i_last_item),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_result_valid  (o_result_valid),
        .o_chosen_mask   (o_chosen_mask),
        .o_total_profit  (o_total_profit),
        .o_total_weight  (o_total_weight),
        .o_nodes_visited (o_nodes_visited)
    );

endmodule

FILE: rtl/kbb_ctrl.sv
// Sequencer for load, insertion sort and branch-and-bound search.
module kbb_ctrl import kbb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_INS  = 4'd2;
    localparam logic [3:0] S_INIT = 4'd3;
    localparam logic [3:0] S_NODE = 4'd4;
    localparam logic [3:0] S_UNDO = 4'd5;
    localparam logic [3:0] S_BND  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_QADD = 4'd8;
    localparam logic [3:0] S_EXCL = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = OP_NONE;
        o_cmd.rd_bidx = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_bidx = 1'b1;
                if (i_sts.full) begin
                    n_state = i_sts.last ? S_INIT : S_IDLE;
                end else if (i_sts.scan_stop) begin
                    n_state = S_INS;
                end else begin
                    o_cmd.op = OP_SCAN;
                end
            end
            S_INS: begin
                o_cmd.op = OP_INSERT;
                n_state  = i_sts.last ? S_INIT : S_IDLE;
            end
            S_INIT: begin
                o_cmd.op = OP_SINIT;
                n_state  = S_NODE;
            end
            S_NODE: begin
                if (i_sts.phase == PH_ENTER) begin
                    o_cmd.op = OP_NODE;
                end else if (i_sts.phase == PH_EXCL) begin
                    o_cmd.op = OP_BINIT;
                    n_state  = S_BND;
                end else if (i_sts.lvl_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = OP_POP;
                    n_state  = S_UNDO;
                end
            end
            S_UNDO: begin
                o_cmd.op = OP_UNDO;
                n_state  = S_NODE;
            end
            S_BND: begin
                o_cmd.rd_bidx = 1'b1;
                if (i_sts.bnd_end) begin
                    o_cmd.op = OP_EXCL;
                    n_state  = S_NODE;
                end else if (i_sts.bnd_fits) begin
                    o_cmd.op = OP_BSTEP;
                end else begin
                    o_cmd.op = OP_MUL;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_sts.div_done) begin
                    n_state = S_QADD;
                end
            end
            S_QADD: begin
                o_cmd.op = OP_QADD;
                n_state  = S_EXCL;
            end
            S_EXCL: begin
                o_cmd.op = OP_EXCL;
                n_state  = S_NODE;
            end
            S_FIN: begin
                o_cmd.op = OP_FINISH;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/kbb_dp.sv
// Item store, search registers, bound divider and result registers.
module kbb_dp import kbb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CAP_W-1:0]    i_cfg_wr_data,
    input  logic [WGT_W-1:0]    i_item_weight,
    input  logic [VAL_W-1:0]    i_item_value,
    input  logic                i_last_item,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    output logic                o_result_valid,
    output logic [MASK_W-1:0]   o_chosen_mask,
    output logic [PROF_W-1:0]   o_total_profit,
    output logic [CAP_W-1:0]    o_total_weight,
    output logic [NODE_W-1:0]   o_nodes_visited
);

    logic [CAP_W-1:0]  r_cap;
    logic [WGT_W-1:0]  r_w [MAX_ITEMS];
    logic [VAL_W-1:0]  r_v [MAX_ITEMS];
    logic [IDX_W-1:0]  r_lp [MAX_ITEMS];
    t_phase            r_phase [MAX_ITEMS];
    logic [CNT_W-1:0]  r_total;
    logic [WGT_W-1:0]  r_nw;
    logic [VAL_W-1:0]  r_nv;
    logic              r_last;
    logic [CNT_W-1:0]  r_bidx;
    logic [CNT_W-1:0]  r_level;
    logic [MASK_W-1:0] r_path;
    logic [RP_W-1:0]   r_rp;
    logic [CAP_W-1:0]  r_rw;
    logic [RP_W-1:0]   r_best_p;
    logic              r_best_ok;
    logic [CAP_W-1:0]  r_best_w;
    logic [MASK_W-1:0] r_best_mask;
    logic [NODE_W-1:0] r_nodes;
    logic [BND_W-1:0]  r_bnd;
    logic [CAP_W-1:0]  r_bc;
    logic [PRD_W-1:0]  r_quo;
    logic [REM_W-1:0]  r_rem;
    logic [WGT_W-1:0]  r_dvs;
    logic [CNT_W-1:0]  r_dcnt;
    logic              r_o_valid;
    logic [MASK_W-1:0] r_o_mask;
    logic [PROF_W-1:0] r_o_prof;
    logic [CAP_W-1:0]  r_o_wgt;
    logic [NODE_W-1:0] r_o_nodes;

    logic [IDX_W-1:0]  rd_addr;
    logic [WGT_W-1:0]  rd_w;
    logic [VAL_W-1:0]  rd_v;
    logic [IDX_W-1:0]  lvl_idx;
    logic [CNT_W-1:0]  lvl_next;
    logic              k_last;
    logic              node_fits;
    logic              scan_gt;
    logic [CAP_W-1:0]  room;
    logic [RP_W-1:0]   inc_prof;
    logic              better_inc;
    logic              better_cur;
    logic              bnd_ok;
    logic [NODE_W-1:0] nodes_inc;
    logic [REM_W-1:0]  rem_sh;
    logic              rem_ge;
    logic [MASK_W-1:0] out_mask;
    logic [MASK_W-1:0] lvl_bit;

    assign rd_addr  = i_cmd.rd_bidx ? r_bidx[IDX_W-1:0] : r_level[IDX_W-1:0];
    assign rd_w     = r_w[rd_addr];
    assign rd_v     = r_v[rd_addr];
    assign lvl_idx  = r_level[IDX_W-1:0];
    assign lvl_next = r_level + CNT_W'(1);
    assign k_last   = (lvl_next == r_total);
    assign lvl_bit  = MASK_W'(1) << lvl_idx;

    assign node_fits = ({1'b0, r_rw} + (CAP_W+1)'(rd_w)) <= {1'b0, r_cap};
    assign scan_gt   = (32'(r_nv) * 32'(rd_w)) > (32'(rd_v) * 32'(r_nw));
    assign room      = (r_bc <= r_cap) ? (r_cap - r_bc) : '0;

    assign inc_prof   = r_rp + RP_W'(rd_v);
    assign better_inc = !r_best_ok || (inc_prof > r_best_p);
    assign better_cur = !r_best_ok || (r_rp > r_best_p);
    assign bnd_ok     = !r_best_ok || (r_bnd >= BND_W'(r_best_p));
    assign nodes_inc  = (r_nodes == '1) ? r_nodes : r_nodes + NODE_W'(1);

    assign rem_sh = {r_rem[REM_W-2:0], r_quo[PRD_W-1]};
    assign rem_ge = rem_sh >= REM_W'(r_dvs);

    always_comb begin
        out_mask = '0;
        for (int i = 0; i < MAX_ITEMS; i++) begin
            if ((CNT_W'(i) < r_total) && r_best_mask[i]) begin
                out_mask[r_lp[i]] = 1'b1;
            end
        end
    end

    assign o_sts.full      = (r_total == CNT_W'(MAX_ITEMS));
    assign o_sts.last      = r_last;
    assign o_sts.scan_stop = (r_bidx == r_total) || scan_gt;
    assign o_sts.lvl_zero  = (r_level == '0);
    assign o_sts.bnd_end   = (r_bidx == r_total);
    assign o_sts.bnd_fits  = ({1'b0, r_bc} + (CAP_W+1)'(rd_w)) <= {1'b0, r_cap};
    assign o_sts.div_done  = (r_dcnt == CNT_W'(PRD_W-1));
    assign o_sts.phase     = r_phase[lvl_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= '0;
            r_total   <= '0;
            r_level   <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < MAX_ITEMS; i++) begin
                r_phase[i] <= PH_ENTER;
            end
        end else begin
            r_o_valid <= 1'b0;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            unique case (i_cmd.op)
                OP_NONE: begin
                end
                OP_LATCH: begin
                    r_nw   <= i_item_weight;
                    r_nv   <= i_item_value;
                    r_last <= i_last_item;
                    r_bidx <= '0;
                end
                OP_SCAN: begin
                    r_bidx <= r_bidx + CNT_W'(1);
                end
                OP_INSERT: begin
                    for (int j = 1; j < MAX_ITEMS; j++) begin
                        if ((CNT_W'(j) > r_bidx) && (CNT_W'(j) <= r_total)) begin
                            r_w[j]  <= r_w[j-1];
                            r_v[j]  <= r_v[j-1];
                            r_lp[j] <= r_lp[j-1];
                        end
                    end
                    r_w[r_bidx[IDX_W-1:0]]  <= r_nw;
                    r_v[r_bidx[IDX_W-1:0]]  <= r_nv;
                    r_lp[r_bidx[IDX_W-1:0]] <= r_total[IDX_W-1:0];
                    r_total                 <= r_total + CNT_W'(1);
                end
                OP_SINIT: begin
                    r_path      <= '0;
                    r_best_ok   <= 1'b0;
                    r_best_p    <= '0;
                    r_best_w    <= '0;
                    r_best_mask <= '0;
                    r_nodes     <= NODE_W'(1);
                    r_rp        <= '0;
                    r_rw        <= '0;
                    r_level     <= '0;
                    r_phase[0]  <= PH_ENTER;
                end
                OP_NODE: begin
                    r_phase[lvl_idx] <= PH_EXCL;
                    if (node_fits) begin
                        r_path <= r_path | lvl_bit;
                        if (!k_last) begin
                            r_rp    <= inc_prof;
                            r_rw    <= r_rw + CAP_W'(rd_w);
                            r_level <= lvl_next;
                            r_phase[lvl_next[IDX_W-1:0]] <= PH_ENTER;
                            r_nodes <= nodes_inc;
                        end else if (better_inc) begin
                            r_best_ok   <= 1'b1;
                            r_best_p    <= inc_prof;
                            r_best_w    <= r_rw + CAP_W'(rd_w);
                            r_best_mask <= r_path | lvl_bit;
                        end
                    end
                end
                OP_BINIT: begin
                    r_bidx <= lvl_next;
                    r_bnd  <= BND_W'(r_rp);
                    r_bc   <= r_rw;
                end
                OP_BSTEP: begin
                    r_bc   <= r_bc + CAP_W'(rd_w);
                    r_bnd  <= r_bnd + BND_W'(rd_v);
                    r_bidx <= r_bidx + CNT_W'(1);
                end
                OP_MUL: begin
                    r_quo  <= PRD_W'(room) * PRD_W'(rd_v);
                    r_dvs  <= rd_w;
                    r_rem  <= '0;
                    r_dcnt <= '0;
                end
                OP_DIV: begin
                    r_rem  <= rem_ge ? (rem_sh - REM_W'(r_dvs)) : rem_sh;
                    r_quo  <= {r_quo[PRD_W-2:0], rem_ge};
                    r_dcnt <= r_dcnt + CNT_W'(1);
                end
                OP_QADD: begin
                    r_bnd <= r_bnd + BND_W'(r_quo);
                end
                OP_EXCL: begin
                    r_phase[lvl_idx] <= PH_DONE;
                    if (bnd_ok) begin
                        r_path <= r_path & ~lvl_bit;
                        if (!k_last) begin
                            r_level <= lvl_next;
                            r_phase[lvl_next[IDX_W-1:0]] <= PH_ENTER;
                            r_nodes <= nodes_inc;
                        end else if (better_cur) begin
                            r_best_ok   <= 1'b1;
                            r_best_p    <= r_rp;
                            r_best_w    <= r_rw;
                            r_best_mask <= r_path & ~lvl_bit;
                        end
                    end
                end
                OP_POP: begin
                    r_level <= r_level - CNT_W'(1);
                end
                OP_UNDO: begin
                    if (r_phase[lvl_idx] == PH_EXCL) begin
                        r_rp <= r_rp - RP_W'(rd_v);
                        r_rw <= r_rw - CAP_W'(rd_w);
                    end
                end
                OP_FINISH: begin
                    r_o_valid <= 1'b1;
                    r_o_mask  <= out_mask;
                    r_o_prof  <= r_best_p[PROF_W-1:0];
                    r_o_wgt   <= r_best_w;
                    r_o_nodes <= r_nodes;
                    r_total   <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result_valid  = r_o_valid;
    assign o_chosen_mask   = r_o_mask;
    assign o_total_profit  = r_o_prof;
    assign o_total_weight  = r_o_wgt;
    assign o_nodes_visited = r_o_nodes;

endmodule
